FILE: hw/rtl/mqtt_fhp_pkg.sv
// ----------------------------------------------------------------------------
// MQTT fixed header parser package
// Shared types, codes and the flag check used by the parser modules.
// ----------------------------------------------------------------------------
package mqtt_fhp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned LENGTH_W  = 28;
    localparam int unsigned DIGIT_W   = 7;
    localparam int unsigned INDEX_W   = 3;

    // A length field carries at most four varint digits.
    localparam logic [INDEX_W-1:0] MAX_LEN_BYTES = 3'd4;

    typedef enum logic [1:0] {
        STATUS_MORE = 2'd0,
        STATUS_GOOD = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    localparam logic [NIBBLE_W-1:0] TYPE_RESERVED_LO = 4'd0;
    localparam logic [NIBBLE_W-1:0] TYPE_PUBLISH     = 4'd3;
    localparam logic [NIBBLE_W-1:0] TYPE_PUBREL      = 4'd6;
    localparam logic [NIBBLE_W-1:0] TYPE_SUBSCRIBE   = 4'd8;
    localparam logic [NIBBLE_W-1:0] TYPE_UNSUBSCRIBE = 4'd10;
    localparam logic [NIBBLE_W-1:0] TYPE_RESERVED_HI = 4'd15;

    localparam logic [NIBBLE_W-1:0] FLAGS_NONE     = 4'd0;
    localparam logic [NIBBLE_W-1:0] FLAGS_REQUIRED = 4'd2;

    typedef struct packed {
        logic                in_length_phase;
        logic [INDEX_W-1:0]  length_byte_index;
        logic [NIBBLE_W-1:0] held_type;
        logic [NIBBLE_W-1:0] held_flags;
        logic [LENGTH_W-1:0] length_accumulator;
    } parse_state_t;

    typedef struct packed {
        status_t             status;
        logic [NIBBLE_W-1:0] packet_type;
        logic [NIBBLE_W-1:0] packet_flags;
        logic [LENGTH_W-1:0] rem_length;
    } header_result_t;

    // True when the type is usable and its flag nibble is legal for it.
    function automatic logic type_flags_ok(input logic [NIBBLE_W-1:0] ptype,
                                           input logic [NIBBLE_W-1:0] pflags);
        logic ok;
        begin
            case (ptype) inside
                TYPE_RESERVED_LO, TYPE_RESERVED_HI:
                    ok = 1'b0;
                TYPE_PUBLISH:
                    ok = 1'b1;
                TYPE_PUBREL, TYPE_SUBSCRIBE, TYPE_UNSUBSCRIBE:
                    ok = (pflags == FLAGS_REQUIRED);
                default:
                    ok = (pflags == FLAGS_NONE);
            endcase
            return ok;
        end
    endfunction

endpackage

FILE: hw/rtl/mqtt_fhp_if.sv
// ----------------------------------------------------------------------------
// MQTT fixed header parser channels
// Valid/ready channels for the incoming byte stream and the decoded header.
// ----------------------------------------------------------------------------
interface mqtt_fhp_byte_if;
    logic                            valid;
    logic                            ready;
    logic [mqtt_fhp_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface mqtt_fhp_result_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        status;
    logic [mqtt_fhp_pkg::NIBBLE_W-1:0] packet_type;
    logic [mqtt_fhp_pkg::NIBBLE_W-1:0] packet_flags;
    logic [mqtt_fhp_pkg::LENGTH_W-1:0] rem_length;

    modport source (output valid, output status, output packet_type,
                    output packet_flags, output rem_length, input ready);
    modport sink (input valid, input status, input packet_type,
                  input packet_flags, input rem_length, output ready);
endinterface

FILE: hw/rtl/mqtt_fhp_step.sv
// ----------------------------------------------------------------------------
// MQTT fixed header parser step logic
// Decodes one byte against the current parse state: next state and result.
// ----------------------------------------------------------------------------
module mqtt_fhp_step (
    input  mqtt_fhp_pkg::parse_state_t       cur,
    input  logic [mqtt_fhp_pkg::BYTE_W-1:0]  data_byte,
    output mqtt_fhp_pkg::parse_state_t       nxt,
    output mqtt_fhp_pkg::header_result_t     res
);

    logic [mqtt_fhp_pkg::NIBBLE_W-1:0] byte_type;
    logic [mqtt_fhp_pkg::NIBBLE_W-1:0] byte_flags;
    logic [mqtt_fhp_pkg::DIGIT_W-1:0]  digit;
    logic [mqtt_fhp_pkg::LENGTH_W-1:0] digit_placed;
    logic                              more_digits;

    assign byte_type   = data_byte[7:4];
    assign byte_flags  = data_byte[3:0];
    assign digit       = data_byte[6:0];
    assign more_digits = data_byte[7];

    // Base-128 little endian: each digit lands seven bits above the last.
    always_comb
    begin
        case (cur.length_byte_index[1:0])
            2'd0:    digit_placed = {21'd0, digit};
            2'd1:    digit_placed = {14'd0, digit, 7'd0};
            2'd2:    digit_placed = {7'd0, digit, 14'd0};
            default: digit_placed = {digit, 21'd0};
        endcase
    end

    always_comb
    begin
        nxt        = cur;
        res.status = mqtt_fhp_pkg::STATUS_MORE;
        if (!cur.in_length_phase)
        begin
            nxt.held_type          = byte_type;
            nxt.held_flags         = byte_flags;
            nxt.length_accumulator = '0;
            nxt.length_byte_index  = '0;
            if (mqtt_fhp_pkg::type_flags_ok(byte_type, byte_flags))
            begin
                nxt.in_length_phase = 1'b1;
            end
            else
            begin
                res.status = mqtt_fhp_pkg::STATUS_BAD;
            end
        end
        else if (cur.length_byte_index >= mqtt_fhp_pkg::MAX_LEN_BYTES)
        begin
            // A fifth length byte is malformed and is not accumulated.
            res.status            = mqtt_fhp_pkg::STATUS_BAD;
            nxt.in_length_phase   = 1'b0;
            nxt.length_byte_index = '0;
        end
        else
        begin
            nxt.length_accumulator = cur.length_accumulator + digit_placed;
            nxt.length_byte_index  = cur.length_byte_index + 3'd1;
            if (!more_digits)
            begin
                res.status            = mqtt_fhp_pkg::STATUS_GOOD;
                nxt.in_length_phase   = 1'b0;
                nxt.length_byte_index = '0;
            end
        end
        res.packet_type  = nxt.held_type;
        res.packet_flags = nxt.held_flags;
        res.rem_length   = nxt.length_accumulator;
    end

endmodule

FILE: hw/rtl/mqtt_fixed_header_parser.sv
// ----------------------------------------------------------------------------
// MQTT fixed header parser
// An accepted byte's result word is registered onto the output the next cycle.
// Throughput: one byte per cycle unless the output stalls; the single result
// register frees as taken, so a new byte enters the cycle the old word leaves.
// Reset clears the parse state to expect a type byte and empties the output.
// ----------------------------------------------------------------------------
module mqtt_fixed_header_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    mqtt_fhp_byte_if.sink            stream,
    mqtt_fhp_result_if.source        header
);

    mqtt_fhp_pkg::parse_state_t   state_reg;
    mqtt_fhp_pkg::parse_state_t   state_next;
    mqtt_fhp_pkg::header_result_t result_reg;
    mqtt_fhp_pkg::header_result_t result_next;
    logic                         out_valid_reg;
    logic                         accept;

    assign stream.ready = !out_valid_reg || header.ready;
    assign accept       = stream.valid && stream.ready;

    mqtt_fhp_step u_step (
        .cur       (state_reg),
        .data_byte (stream.data_byte),
        .nxt       (state_next),
        .res       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (header.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign header.valid        = out_valid_reg;
    assign header.status       = result_reg.status;
    assign header.packet_type  = result_reg.packet_type;
    assign header.packet_flags = result_reg.packet_flags;
    assign header.rem_length   = result_reg.rem_length;

endmodule
